@@ rtl/core/rpvg_pkg.sv @@
// Shared types, codes and rounding helpers for the relative pose gate.
`timescale 1ns / 1ps
package rpvg_pkg;

   localparam int QW = 16;   // quaternion component width, Q1.14
   localparam int TW = 24;   // translation width, Q12.12
   localparam int DW = 48;   // squared distance width, Q24.24
   localparam int IW = 32;   // pose id width
   localparam int MW = 34;   // rotation matrix entry width, Q.28
   localparam int PW = MW + TW;      // matrix times translation product
   localparam int SW = PW + 2;       // sum of three products

   localparam int unsigned DEF_MIN_DELTA = 1;
   localparam int unsigned DEF_MAX_DELTA = 1024;
   localparam logic [DW-1:0] DEF_MIN_RANGE_SQ = '0;
   localparam int unsigned DEF_COS_HALF_MAX_ANGLE = 11585;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT    = 3'd0,
      VERDICT_NOT_OLDER = 3'd1,
      VERDICT_TOO_OLD   = 3'd2,
      VERDICT_TOO_NEW   = 3'd3,
      VERDICT_RANGE     = 3'd4,
      VERDICT_ANGLE     = 3'd5
   } verdict_type;

   typedef enum logic [2:0] {
      CSR_ROT_W   = 3'd0,
      CSR_ROT_X   = 3'd1,
      CSR_ROT_Y   = 3'd2,
      CSR_ROT_Z   = 3'd3,
      CSR_TRANS_X = 3'd4,
      CSR_TRANS_Y = 3'd5,
      CSR_TRANS_Z = 3'd6,
      CSR_RANGE   = 3'd7
   } csr_index_type;

   // Round Q2.28 half up to Q1.14 and clamp to the unit range.
   function automatic logic signed [QW-1:0] quat_out(input logic signed [MW-1:0] v);
      logic signed [MW-1:0] r;
      r = (v + MW'(signed'(1 <<< 13))) >>> 14;
      if (r > MW'(signed'(16384)))
         return QW'(16384);
      else if (r < -MW'(signed'(16384)))
         return -QW'(16384);
      else
         return r[QW-1:0];
   endfunction

   // Round Q.40 half up to Q12.12, add offset and saturate to 24 bits.
   function automatic logic signed [TW-1:0] trans_out(input logic signed [SW-1:0] v,
                                                       input logic signed [TW-1:0] off);
      logic signed [SW-1:0] r;
      r = ((v + SW'(signed'(1 <<< 27))) >>> 28) + SW'(off);
      if (r > SW'(signed'(8388607)))
         return TW'(8388607);
      else if (r < -SW'(signed'(8388608)))
         return TW'(-8388608);
      else
         return r[TW-1:0];
   endfunction

endpackage

@@ rtl/core/rpvg_pose_math.sv @@
// Four stage pose composition: relative quaternion and rotated translation.
`timescale 1ns / 1ps
module rpvg_pose_math (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [rpvg_pkg::QW-1:0]      aw, ax, ay, az,
   input  logic signed [rpvg_pkg::TW-1:0]      off_x, off_y, off_z,
   input  logic signed [rpvg_pkg::QW-1:0]      bw, bx, by, bz,
   input  logic signed [rpvg_pkg::TW-1:0]      tx, ty, tz,
   output logic signed [rpvg_pkg::QW-1:0]      rel_w, rel_x, rel_y, rel_z,
   output logic signed [rpvg_pkg::TW-1:0]      rel_tx, rel_ty, rel_tz
);
   localparam int QW = rpvg_pkg::QW;
   localparam int TW = rpvg_pkg::TW;
   localparam int MW = rpvg_pkg::MW;
   localparam int PW = rpvg_pkg::PW;
   localparam int SW = rpvg_pkg::SW;
   localparam int XW = 2 * QW;

   // stage 1: products
   logic signed [XW-1:0] qp_ff [16];
   logic signed [XW-1:0] mp_ff [9];
   logic signed [TW-1:0] t1_ff [3];
   // stage 2: quaternion sums, matrix entries
   logic signed [QW-1:0] q2_ff [4];
   logic signed [MW-1:0] m2_ff [9];
   logic signed [TW-1:0] t2_ff [3];
   // stage 3: matrix times translation
   logic signed [QW-1:0] q3_ff [4];
   logic signed [PW-1:0] p3_ff [9];
   // stage 4: outputs
   logic signed [QW-1:0] q4_ff [4];
   logic signed [TW-1:0] r4_ff [3];

   logic signed [MW-1:0] qs_in [4];
   logic signed [MW-1:0] m2_in [9];
   logic signed [MW-1:0] one_q28;

   assign one_q28 = MW'(signed'(1 <<< 28));

   // Form quaternion sums and the rotation matrix of the inverse pose.
   always_comb begin
      qs_in[0] = MW'(qp_ff[0]) - MW'(qp_ff[1]) - MW'(qp_ff[2]) - MW'(qp_ff[3]);
      qs_in[1] = MW'(qp_ff[4]) + MW'(qp_ff[5]) + MW'(qp_ff[6]) - MW'(qp_ff[7]);
      qs_in[2] = MW'(qp_ff[8]) - MW'(qp_ff[9]) + MW'(qp_ff[10]) + MW'(qp_ff[11]);
      qs_in[3] = MW'(qp_ff[12]) + MW'(qp_ff[13]) - MW'(qp_ff[14]) + MW'(qp_ff[15]);
      // mp: 0 xx, 1 yy, 2 zz, 3 xy, 4 xz, 5 yz, 6 wx, 7 wy, 8 wz
      m2_in[0] = one_q28 - ((MW'(mp_ff[1]) + MW'(mp_ff[2])) <<< 1);
      m2_in[1] = (MW'(mp_ff[3]) - MW'(mp_ff[8])) <<< 1;
      m2_in[2] = (MW'(mp_ff[4]) + MW'(mp_ff[7])) <<< 1;
      m2_in[3] = (MW'(mp_ff[3]) + MW'(mp_ff[8])) <<< 1;
      m2_in[4] = one_q28 - ((MW'(mp_ff[0]) + MW'(mp_ff[2])) <<< 1);
      m2_in[5] = (MW'(mp_ff[5]) - MW'(mp_ff[6])) <<< 1;
      m2_in[6] = (MW'(mp_ff[4]) - MW'(mp_ff[7])) <<< 1;
      m2_in[7] = (MW'(mp_ff[5]) + MW'(mp_ff[6])) <<< 1;
      m2_in[8] = one_q28 - ((MW'(mp_ff[0]) + MW'(mp_ff[1])) <<< 1);
   end

   // Advance all stages together when the pipeline is not stalled.
   always_ff @(posedge clock) begin
      if (en) begin
         qp_ff[0]  <= aw * bw;  qp_ff[1]  <= ax * bx;
         qp_ff[2]  <= ay * by;  qp_ff[3]  <= az * bz;
         qp_ff[4]  <= aw * bx;  qp_ff[5]  <= ax * bw;
         qp_ff[6]  <= ay * bz;  qp_ff[7]  <= az * by;
         qp_ff[8]  <= aw * by;  qp_ff[9]  <= ax * bz;
         qp_ff[10] <= ay * bw;  qp_ff[11] <= az * bx;
         qp_ff[12] <= aw * bz;  qp_ff[13] <= ax * by;
         qp_ff[14] <= ay * bx;  qp_ff[15] <= az * bw;
         mp_ff[0] <= ax * ax;  mp_ff[1] <= ay * ay;  mp_ff[2] <= az * az;
         mp_ff[3] <= ax * ay;  mp_ff[4] <= ax * az;  mp_ff[5] <= ay * az;
         mp_ff[6] <= aw * ax;  mp_ff[7] <= aw * ay;  mp_ff[8] <= aw * az;
         t1_ff[0] <= tx;  t1_ff[1] <= ty;  t1_ff[2] <= tz;

         for (int i = 0; i < 4; i++) begin
            q2_ff[i] <= rpvg_pkg::quat_out(qs_in[i]);
            q3_ff[i] <= q2_ff[i];
            q4_ff[i] <= q3_ff[i];
         end
         for (int i = 0; i < 9; i++) begin
            m2_ff[i] <= m2_in[i];
            p3_ff[i] <= PW'(m2_ff[i]) * PW'(t2_ff[i % 3]);
         end
         for (int i = 0; i < 3; i++)
            t2_ff[i] <= t1_ff[i];

         r4_ff[0] <= rpvg_pkg::trans_out(SW'(p3_ff[0]) + SW'(p3_ff[1]) + SW'(p3_ff[2]), off_x);
         r4_ff[1] <= rpvg_pkg::trans_out(SW'(p3_ff[3]) + SW'(p3_ff[4]) + SW'(p3_ff[5]), off_y);
         r4_ff[2] <= rpvg_pkg::trans_out(SW'(p3_ff[6]) + SW'(p3_ff[7]) + SW'(p3_ff[8]), off_z);
      end
   end

   assign rel_w  = q4_ff[0];
   assign rel_x  = q4_ff[1];
   assign rel_y  = q4_ff[2];
   assign rel_z  = q4_ff[3];
   assign rel_tx = r4_ff[0];
   assign rel_ty = r4_ff[1];
   assign rel_tz = r4_ff[2];

endmodule

@@ rtl/core/relative_pose_visibility_gate_core.sv @@
// Top level of the relative pose visibility gate: id gating, range and angle tests.
// A result passes through six register stages after the input transfer.
// Throughput: one pair per cycle; the six stage pipeline holds as a whole
// only while a finished result is not taken.
// Reset: synchronous; clears all stage valid bits and loads the identity pose
// and a 100 square meter range limit.
`timescale 1ns / 1ps
module relative_pose_visibility_gate_core #(
   parameter int unsigned MIN_DELTA = rpvg_pkg::DEF_MIN_DELTA,
   parameter int unsigned MAX_DELTA = rpvg_pkg::DEF_MAX_DELTA,
   parameter logic [rpvg_pkg::DW-1:0] MIN_RANGE_SQ = rpvg_pkg::DEF_MIN_RANGE_SQ,
   parameter int unsigned COS_HALF_MAX_ANGLE = rpvg_pkg::DEF_COS_HALF_MAX_ANGLE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [2:0]                       csr_index,
   input  logic [rpvg_pkg::DW-1:0]          csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [rpvg_pkg::QW-1:0]   req_other_w,
   input  logic signed [rpvg_pkg::QW-1:0]   req_other_x,
   input  logic signed [rpvg_pkg::QW-1:0]   req_other_y,
   input  logic signed [rpvg_pkg::QW-1:0]   req_other_z,
   input  logic signed [rpvg_pkg::TW-1:0]   req_other_tx,
   input  logic signed [rpvg_pkg::TW-1:0]   req_other_ty,
   input  logic signed [rpvg_pkg::TW-1:0]   req_other_tz,
   input  logic [rpvg_pkg::IW-1:0]          req_other_id,
   input  logic [rpvg_pkg::IW-1:0]          req_current_id,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_verdict,
   output logic signed [rpvg_pkg::QW-1:0]   rsp_rel_w,
   output logic signed [rpvg_pkg::QW-1:0]   rsp_rel_x,
   output logic signed [rpvg_pkg::QW-1:0]   rsp_rel_y,
   output logic signed [rpvg_pkg::QW-1:0]   rsp_rel_z,
   output logic signed [rpvg_pkg::TW-1:0]   rsp_rel_tx,
   output logic signed [rpvg_pkg::TW-1:0]   rsp_rel_ty,
   output logic signed [rpvg_pkg::TW-1:0]   rsp_rel_tz
);
   localparam int QW = rpvg_pkg::QW;
   localparam int TW = rpvg_pkg::TW;
   localparam int DW = rpvg_pkg::DW;
   localparam int IW = rpvg_pkg::IW;
   localparam int NS = 6;
   localparam int AW = DW - 1;

   logic signed [QW-1:0] rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   logic signed [TW-1:0] trn_x_ff, trn_y_ff, trn_z_ff;
   logic [DW-1:0]        range_ff;

   logic [NS-1:0]             vld_ff;
   rpvg_pkg::verdict_type     code_ff [5];
   logic                      en;

   logic signed [QW-1:0] m_w, m_x, m_y, m_z;
   logic signed [TW-1:0] m_tx, m_ty, m_tz;

   logic signed [QW-1:0] q5_ff [4];
   logic signed [TW-1:0] t5_ff [3];
   logic [AW-1:0]        sq5_ff [3];

   rpvg_pkg::verdict_type code_in, verdict_in, verdict_ff;
   logic signed [QW-1:0]  q6_ff [4];
   logic signed [TW-1:0]  t6_ff [3];
   logic [IW-1:0]         delta;
   logic [DW-1:0]         d2;
   logic [QW-1:0]         absw;

   // Hold the whole pipeline while a result waits to be taken.
   assign en        = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = en;

   // Write configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff <= QW'(16384);
         rot_x_ff <= '0;
         rot_y_ff <= '0;
         rot_z_ff <= '0;
         trn_x_ff <= '0;
         trn_y_ff <= '0;
         trn_z_ff <= '0;
         range_ff <= DW'(64'd1677721600);
      end else if (csr_write_en) begin
         case (rpvg_pkg::csr_index_type'(csr_index))
            rpvg_pkg::CSR_ROT_W:   rot_w_ff <= csr_wdata[QW-1:0];
            rpvg_pkg::CSR_ROT_X:   rot_x_ff <= csr_wdata[QW-1:0];
            rpvg_pkg::CSR_ROT_Y:   rot_y_ff <= csr_wdata[QW-1:0];
            rpvg_pkg::CSR_ROT_Z:   rot_z_ff <= csr_wdata[QW-1:0];
            rpvg_pkg::CSR_TRANS_X: trn_x_ff <= csr_wdata[TW-1:0];
            rpvg_pkg::CSR_TRANS_Y: trn_y_ff <= csr_wdata[TW-1:0];
            rpvg_pkg::CSR_TRANS_Z: trn_z_ff <= csr_wdata[TW-1:0];
            rpvg_pkg::CSR_RANGE:   range_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Gate on id distance at entry.
   always_comb begin
      delta = req_current_id - req_other_id;
      if (req_other_id >= req_current_id)
         code_in = rpvg_pkg::VERDICT_NOT_OLDER;
      else if (delta > IW'(MAX_DELTA))
         code_in = rpvg_pkg::VERDICT_TOO_OLD;
      else if (delta < IW'(MIN_DELTA))
         code_in = rpvg_pkg::VERDICT_TOO_NEW;
      else
         code_in = rpvg_pkg::VERDICT_ACCEPT;
   end

   rpvg_pose_math u_math (
      .clock  (clock),
      .en     (en),
      .aw     (rot_w_ff),
      .ax     (rot_x_ff),
      .ay     (rot_y_ff),
      .az     (rot_z_ff),
      .off_x  (trn_x_ff),
      .off_y  (trn_y_ff),
      .off_z  (trn_z_ff),
      .bw     (req_other_w),
      .bx     (req_other_x),
      .by     (req_other_y),
      .bz     (req_other_z),
      .tx     (req_other_tx),
      .ty     (req_other_ty),
      .tz     (req_other_tz),
      .rel_w  (m_w),
      .rel_x  (m_x),
      .rel_y  (m_y),
      .rel_z  (m_z),
      .rel_tx (m_tx),
      .rel_ty (m_ty),
      .rel_tz (m_tz)
   );

   // Advance valid bits with the data.
   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (en)
         vld_ff <= {vld_ff[NS-2:0], req_valid};
   end

   // Final tests on squared distance and rotation angle.
   always_comb begin
      d2   = DW'(sq5_ff[0]) + DW'(sq5_ff[1]) + DW'(sq5_ff[2]);
      absw = q5_ff[0][QW-1] ? QW'(-q5_ff[0]) : q5_ff[0];
      if (code_ff[4] != rpvg_pkg::VERDICT_ACCEPT)
         verdict_in = code_ff[4];
      else if (d2 < MIN_RANGE_SQ || d2 > range_ff)
         verdict_in = rpvg_pkg::VERDICT_RANGE;
      else if (absw < QW'(COS_HALF_MAX_ANGLE))
         verdict_in = rpvg_pkg::VERDICT_ANGLE;
      else
         verdict_in = rpvg_pkg::VERDICT_ACCEPT;
   end

   // Carry id code, square distances, register result.
   always_ff @(posedge clock) begin
      if (en) begin
         code_ff[0] <= code_in;
         for (int i = 1; i < 5; i++)
            code_ff[i] <= code_ff[i-1];
         q5_ff[0] <= m_w;  q5_ff[1] <= m_x;  q5_ff[2] <= m_y;  q5_ff[3] <= m_z;
         t5_ff[0] <= m_tx; t5_ff[1] <= m_ty; t5_ff[2] <= m_tz;
         sq5_ff[0] <= AW'(DW'(m_tx) * DW'(m_tx));
         sq5_ff[1] <= AW'(DW'(m_ty) * DW'(m_ty));
         sq5_ff[2] <= AW'(DW'(m_tz) * DW'(m_tz));
         verdict_ff <= verdict_in;
         for (int i = 0; i < 4; i++)
            q6_ff[i] <= q5_ff[i];
         for (int i = 0; i < 3; i++)
            t6_ff[i] <= t5_ff[i];
      end
   end

   assign rsp_valid   = vld_ff[NS-1];
   assign rsp_verdict = verdict_ff;
   assign rsp_rel_w   = q6_ff[0];
   assign rsp_rel_x   = q6_ff[1];
   assign rsp_rel_y   = q6_ff[2];
   assign rsp_rel_z   = q6_ff[3];
   assign rsp_rel_tx  = t6_ff[0];
   assign rsp_rel_ty  = t6_ff[1];
   assign rsp_rel_tz  = t6_ff[2];

   a_no_valid_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid right after reset");

   a_accept_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict == rpvg_pkg::VERDICT_ACCEPT) |->
      (rsp_rel_w >= QW'(COS_HALF_MAX_ANGLE) || -rsp_rel_w >= QW'(COS_HALF_MAX_ANGLE)))
      else $error("accepted pair with too large angle");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_verdict) && !$past(req_ready)))
      else $error("pipeline moved while result stalled");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the relative pose visibility gate core.
`timescale 1ns / 1ps
module tb;
   localparam int QW = rpvg_pkg::QW;
   localparam int TW = rpvg_pkg::TW;
   localparam int DW = rpvg_pkg::DW;
   localparam int IW = rpvg_pkg::IW;

   typedef struct {
      logic signed [QW-1:0] w, x, y, z;
      logic signed [TW-1:0] tx, ty, tz;
      logic [IW-1:0]        oid, cid;
   } pose_pair_type;

   typedef struct {
      rpvg_pkg::verdict_type verdict;
      logic signed [QW-1:0]  w, x, y, z;
      logic signed [TW-1:0]  tx, ty, tz;
   } gate_result_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_en = 0;
   logic [2:0] csr_index = rpvg_pkg::CSR_ROT_W;
   logic [DW-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_ready;
   logic signed [QW-1:0] req_other_w = 0, req_other_x = 0, req_other_y = 0, req_other_z = 0;
   logic signed [TW-1:0] req_other_tx = 0, req_other_ty = 0, req_other_tz = 0;
   logic [IW-1:0] req_other_id = 0, req_current_id = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_verdict;
   logic signed [QW-1:0] rsp_rel_w, rsp_rel_x, rsp_rel_y, rsp_rel_z;
   logic signed [TW-1:0] rsp_rel_tx, rsp_rel_ty, rsp_rel_tz;

   relative_pose_visibility_gate_core DUT (.*);

   always #5 clock = ~clock;

   // Local copy of the inverse robot pose and range limit
   logic signed [QW-1:0] inv_w = 16384, inv_x = 0, inv_y = 0, inv_z = 0;
   logic signed [TW-1:0] inv_tx = 0, inv_ty = 0, inv_tz = 0;
   logic [DW-1:0] range_limit = 48'd1677721600;

   pose_pair_type   pending_pairs[$];
   gate_result_type expected_results[$];
   int errors = 0;
   int cycles = 0;
   int gap_mode = 1;
   int stall_mode = 1;
   int verdict_seen[8];

   function automatic longint round_quat(longint v);
      longint r;
      r = (v + (64'sd1 <<< 13)) >>> 14;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic longint round_trans(longint r0, longint r1, longint r2,
                                          longint tx, longint ty, longint tz, longint off);
      longint r;
      r = ((r0 * tx + r1 * ty + r2 * tz + (64'sd1 <<< 27)) >>> 28) + off;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r;
   endfunction

   // Compose the inverse robot pose with the other pose and gate the pair
   function automatic gate_result_type compose_and_gate(pose_pair_type p);
      gate_result_type res;
      longint aw, ax, ay, az, bw, bx, by, bz, tx, ty, tz, one, px, py, pz, rw;
      longint unsigned d2, absw;
      logic [IW-1:0] delta;
      aw = inv_w; ax = inv_x; ay = inv_y; az = inv_z;
      bw = p.w; bx = p.x; by = p.y; bz = p.z;
      tx = p.tx; ty = p.ty; tz = p.tz;
      one = 64'sd1 <<< 28;
      rw = round_quat(aw * bw - ax * bx - ay * by - az * bz);
      res.w = QW'(rw);
      res.x = QW'(round_quat(aw * bx + ax * bw + ay * bz - az * by));
      res.y = QW'(round_quat(aw * by - ax * bz + ay * bw + az * bx));
      res.z = QW'(round_quat(aw * bz + ax * by - ay * bx + az * bw));
      px = round_trans(one - 2 * (ay * ay + az * az), 2 * (ax * ay - aw * az),
                       2 * (ax * az + aw * ay), tx, ty, tz, longint'(inv_tx));
      py = round_trans(2 * (ax * ay + aw * az), one - 2 * (ax * ax + az * az),
                       2 * (ay * az - aw * ax), tx, ty, tz, longint'(inv_ty));
      pz = round_trans(2 * (ax * az - aw * ay), 2 * (ay * az + aw * ax),
                       one - 2 * (ax * ax + ay * ay), tx, ty, tz, longint'(inv_tz));
      res.tx = TW'(px); res.ty = TW'(py); res.tz = TW'(pz);
      d2 = px * px + py * py + pz * pz;
      absw = (rw < 0) ? -rw : rw;
      delta = p.cid - p.oid;
      if (p.oid >= p.cid) res.verdict = rpvg_pkg::VERDICT_NOT_OLDER;
      else if (delta > rpvg_pkg::DEF_MAX_DELTA) res.verdict = rpvg_pkg::VERDICT_TOO_OLD;
      else if (delta < rpvg_pkg::DEF_MIN_DELTA) res.verdict = rpvg_pkg::VERDICT_TOO_NEW;
      else if (d2 < rpvg_pkg::DEF_MIN_RANGE_SQ || d2 > range_limit)
         res.verdict = rpvg_pkg::VERDICT_RANGE;
      else if (absw < rpvg_pkg::DEF_COS_HALF_MAX_ANGLE) res.verdict = rpvg_pkg::VERDICT_ANGLE;
      else res.verdict = rpvg_pkg::VERDICT_ACCEPT;
      return res;
   endfunction

   function automatic int pick_gap(int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0 || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: hold the pair until transfer, then load the next one or idle
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 0;
         end else if (pending_pairs.size() > 0) begin
            pose_pair_type p;
            p = pending_pairs.pop_front();
            req_other_w <= p.w; req_other_x <= p.x;
            req_other_y <= p.y; req_other_z <= p.z;
            req_other_tx <= p.tx; req_other_ty <= p.ty; req_other_tz <= p.tz;
            req_other_id <= p.oid; req_current_id <= p.cid;
            req_valid <= 1;
            req_gap <= pick_gap(gap_mode);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Predict on every input transfer
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         pose_pair_type p;
         p.w = req_other_w; p.x = req_other_x; p.y = req_other_y; p.z = req_other_z;
         p.tx = req_other_tx; p.ty = req_other_ty; p.tz = req_other_tz;
         p.oid = req_other_id; p.cid = req_current_id;
         expected_results.push_back(compose_and_gate(p));
      end
   end

   // Result side: random stalls and field by field compare
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            rsp_gap <= pick_gap(stall_mode);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result verdict=%0d", $time, rsp_verdict);
               errors++;
            end else begin
               gate_result_type e;
               e = expected_results.pop_front();
               verdict_seen[e.verdict]++;
               if (rsp_verdict !== e.verdict || rsp_rel_w !== e.w || rsp_rel_x !== e.x ||
                   rsp_rel_y !== e.y || rsp_rel_z !== e.z || rsp_rel_tx !== e.tx ||
                   rsp_rel_ty !== e.ty || rsp_rel_tz !== e.tz) begin
                  $display("%0t: mismatch expected v=%0d q=(%0d %0d %0d %0d) t=(%0d %0d %0d)",
                           $time, e.verdict, e.w, e.x, e.y, e.z, e.tx, e.ty, e.tz);
                  $display("%0t:          actual v=%0d q=(%0d %0d %0d %0d) t=(%0d %0d %0d)",
                           $time, rsp_verdict, rsp_rel_w, rsp_rel_x, rsp_rel_y,
                           rsp_rel_z, rsp_rel_tx, rsp_rel_ty, rsp_rel_tz);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(rpvg_pkg::csr_index_type idx, logic [DW-1:0] value);
      @(posedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         rpvg_pkg::CSR_ROT_W:   inv_w = value[QW-1:0];
         rpvg_pkg::CSR_ROT_X:   inv_x = value[QW-1:0];
         rpvg_pkg::CSR_ROT_Y:   inv_y = value[QW-1:0];
         rpvg_pkg::CSR_ROT_Z:   inv_z = value[QW-1:0];
         rpvg_pkg::CSR_TRANS_X: inv_tx = value[TW-1:0];
         rpvg_pkg::CSR_TRANS_Y: inv_ty = value[TW-1:0];
         rpvg_pkg::CSR_TRANS_Z: inv_tz = value[TW-1:0];
         default:               range_limit = value;
      endcase
   endtask

   task automatic load_pose(int w, int x, int y, int z, int tx, int ty, int tz,
                            logic [DW-1:0] limit);
      write_reg(rpvg_pkg::CSR_ROT_W, DW'(w));
      write_reg(rpvg_pkg::CSR_ROT_X, DW'(x));
      write_reg(rpvg_pkg::CSR_ROT_Y, DW'(y));
      write_reg(rpvg_pkg::CSR_ROT_Z, DW'(z));
      write_reg(rpvg_pkg::CSR_TRANS_X, DW'(tx));
      write_reg(rpvg_pkg::CSR_TRANS_Y, DW'(ty));
      write_reg(rpvg_pkg::CSR_TRANS_Z, DW'(tz));
      write_reg(rpvg_pkg::CSR_RANGE, limit);
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   task automatic add_pair(int w, int x, int y, int z, int tx, int ty, int tz,
                           logic [IW-1:0] oid, logic [IW-1:0] cid);
      pose_pair_type p;
      p.w = QW'(w); p.x = QW'(x); p.y = QW'(y); p.z = QW'(z);
      p.tx = TW'(tx); p.ty = TW'(ty); p.tz = TW'(tz); p.oid = oid; p.cid = cid;
      pending_pairs.push_back(p);
   endtask

   function automatic int rand_span(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // Mostly near-unit poses at short range with plausible id gaps; some noise
   task automatic add_random_pairs(int count);
      int w, x, y, z, t, ix, iy, iz;
      logic [IW-1:0] cid, oid;
      repeat (count) begin
         if ($urandom_range(0, 3) != 0) begin
            w = $urandom_range(9000, 16384);
            if ($urandom_range(0, 1)) w = -w;
            x = rand_span(9000); y = rand_span(9000); z = rand_span(9000);
         end else begin
            w = rand_span(16384); x = rand_span(16384);
            y = rand_span(16384); z = rand_span(16384);
         end
         t = ($urandom_range(0, 4) == 0) ? 8388607 : 60000;
         ix = rand_span(t); iy = rand_span(t); iz = rand_span(t);
         if ($urandom_range(0, 9) == 0) ix = -8388608;
         cid = $urandom;
         case ($urandom_range(0, 9))
            0:       oid = $urandom;
            1:       oid = cid - $urandom_range(1025, 5000);
            default: oid = cid - $urandom_range(1, 1024);
         endcase
         add_pair(w, x, y, z, ix, iy, iz, oid, cid);
      end
   endtask

   task automatic drain();
      while (pending_pairs.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // Phase 0: identity pose, directed corners
      load_pose(16384, 0, 0, 0, 0, 0, 0, 48'd1677721600);
      add_pair(16384, 0, 0, 0, 0, 0, 0, 5, 6);
      add_pair(16384, 0, 0, 0, 4096, 0, 0, 100, 100);
      add_pair(16384, 0, 0, 0, 4096, 0, 0, 101, 100);
      add_pair(16384, 0, 0, 0, 4096, 0, 0, 32'hFFFFFFFF, 0);
      add_pair(16384, 0, 0, 0, 4096, 0, 0, 0, 32'hFFFFFFFF);
      add_pair(16384, 0, 0, 0, 4096, 0, 0, 0, 1024);
      add_pair(16384, 0, 0, 0, 4096, 0, 0, 0, 1025);
      add_pair(-16384, 0, 0, 0, 40960, 0, 0, 10, 11);
      add_pair(16384, 0, 0, 0, 40961, 0, 0, 10, 11);
      add_pair(16384, 0, 0, 0, 8388607, 8388607, 8388607, 10, 11);
      add_pair(16384, 0, 0, 0, -8388608, -8388608, -8388608, 10, 11);
      add_pair(11585, 11585, 0, 0, 100, 200, 300, 10, 11);
      add_pair(11584, 0, 11585, 0, 100, 200, 300, 10, 11);
      add_pair(0, 16384, 0, 0, 0, 4096, 0, 10, 11);
      add_pair(16384, 16384, 16384, 16384, 1, -1, 1, 10, 11);
      add_pair(-16384, -16384, -16384, -16384, -1, 1, -1, 10, 11);
      add_pair(8192, -8192, 8192, -8192, 2048, -2048, 2048, 10, 11);
      add_pair(0, 0, 0, 0, 0, 0, 0, 10, 11);
      add_random_pairs(130);
      drain();

      // Phase 1: flipped identity, extreme offsets, unlimited range, no idling
      gap_mode = 0; stall_mode = 0;
      load_pose(-16384, 0, 0, 0, 8388607, -8388608, 0, 48'hFFFFFFFFFFFF);
      add_random_pairs(140);
      drain();

      // Phase 2: quarter turn about z, larger range
      gap_mode = 1; stall_mode = 1;
      load_pose(11585, 0, 0, 11585, 4096, -4096, 100, 48'd6710886400);
      add_random_pairs(140);
      drain();

      // Phase 3: half turn about x, zero range limit
      stall_mode = 0;
      load_pose(0, 16384, 0, 0, -8388608, 8388607, -8388608, 48'd0);
      add_random_pairs(140);
      drain();

      // Phase 4: non-unit extreme quaternion
      stall_mode = 1; gap_mode = 0;
      load_pose(16384, -16384, 16384, -16384, 0, 0, 0, 48'hFFFFFFFFFFFF);
      add_random_pairs(140);
      drain();

      // Phases 5 to 7: random poses and limits
      gap_mode = 1;
      repeat (3) begin
         load_pose(rand_span(16384), rand_span(16384), rand_span(16384), rand_span(16384),
                   rand_span(8388607), rand_span(8388607), rand_span(8388607),
                   {16'($urandom_range(0, 65535)), $urandom});
         add_random_pairs(140);
         drain();
      end

      $display("Covered %0d cycles across eight pose settings; verdicts accept=%0d",
               cycles, verdict_seen[0]);
      $display("not older=%0d too old=%0d range=%0d angle=%0d",
               verdict_seen[1], verdict_seen[2], verdict_seen[4], verdict_seen[5]);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/rpvg_pkg.sv
rtl/core/rpvg_pose_math.sv
rtl/core/relative_pose_visibility_gate_core.sv
tb/sv/tb.sv
